/* design/dfrw_pkg.sv */
// ----------------------------------------------------------------------------
// dfrw_pkg: shared types and constants of the delayed feedback random walk
// Field widths, configuration register indexes, reset values and the control
// struct between the step stage and the histogram stage.
// ----------------------------------------------------------------------------
package dfrw_pkg;

  localparam int VALUE_W   = 5;   // new_value field
  localparam int COUNT_W   = 32;  // bin_count field
  localparam int DRAW_W    = 16;  // rand_draw field
  localparam int CFG_W     = 5;   // widest configuration register
  localparam int CFG_IDX_W = 2;

  // Every delay code the 5-bit registers can hold
  localparam int DELAY_SPAN = 2 ** CFG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DELAY_A   = 2'd1,
    REG_DELAY_B   = 2'd2
  } cfg_reg_t;

  localparam logic signed [CFG_W-1:0] THRESHOLD_RST = 5'sd0;
  localparam logic [CFG_W-1:0]        DELAY_A_RST   = 5'd1;
  localparam logic [CFG_W-1:0]        DELAY_B_RST   = 5'd0;

  // Step stage to histogram stage
  typedef struct packed {
    logic adv;      // item moves into the histogram stage this cycle
    logic restart;  // histogram is cleared before this item
  } step_ctl_t;

endpackage

/* design/dfrw_in_if.sv */
// ----------------------------------------------------------------------------
// dfrw_in_if: input item channel
// Valid/ready channel carrying restart and rand_draw.
// ----------------------------------------------------------------------------
interface dfrw_in_if;
  import dfrw_pkg::*;

  logic              valid;
  logic              ready;
  logic              restart;
  logic [DRAW_W-1:0] rand_draw;

  modport source (output valid, output restart, output rand_draw, input ready);
  modport sink   (input valid, input restart, input rand_draw, output ready);
endinterface

/* design/dfrw_out_if.sv */
// ----------------------------------------------------------------------------
// dfrw_out_if: result item channel
// Valid/ready channel carrying new_value and bin_count.
// ----------------------------------------------------------------------------
interface dfrw_out_if;
  import dfrw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] new_value;
  logic [COUNT_W-1:0]        bin_count;

  modport source (output valid, output new_value, output bin_count, input ready);
  modport sink   (input valid, input new_value, input bin_count, output ready);
endinterface

/* design/dfrw_ram.sv */
// ----------------------------------------------------------------------------
// dfrw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module dfrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 21
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/dfrw_step.sv */
// ----------------------------------------------------------------------------
// dfrw_step: input register, history line and walk step
// Holds the accepted item, the last walk values as a shift line, and decides
// the next walk value from the two delayed feedback taps.
// ----------------------------------------------------------------------------
module dfrw_step #(
  parameter int HALF_RANGE    = 10,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                                              clk,
  input  logic                                              rst,
  dfrw_in_if.sink                                           item_in,
  input  logic signed [dfrw_pkg::CFG_W-1:0]                 threshold,
  input  logic [dfrw_pkg::CFG_W-1:0]                        delay_a,
  input  logic [dfrw_pkg::CFG_W-1:0]                        delay_b,
  input  logic                                              hist_ready,
  output dfrw_pkg::step_ctl_t                               ctl,
  output logic signed [$clog2(HALF_RANGE + 1):0]            value,
  output logic [$clog2(2 * HALF_RANGE + 1)-1:0]             bin
);
  import dfrw_pkg::*;

  localparam int VW = $clog2(HALF_RANGE + 1) + 1;
  localparam int BW = $clog2(2 * HALF_RANGE + 1);
  localparam int CW = (VW > CFG_W ? VW : CFG_W) + 1;
  // Delays are at most DELAY_SPAN-1, so at most DELAY_SPAN values are ever seen
  localparam int LEN = HISTORY_DEPTH < DELAY_SPAN ? HISTORY_DEPTH : DELAY_SPAN;

  localparam logic signed [VW-1:0] HR_POS = VW'(HALF_RANGE);
  localparam logic signed [VW-1:0] HR_NEG = -VW'(HALF_RANGE);
  localparam logic signed [VW-1:0] ONE    = VW'(1);

  logic              a_valid;
  logic              a_restart;
  logic [DRAW_W-1:0] a_draw;
  logic              adv;

  logic signed [VW-1:0] hist_line [LEN];  // [0] is the current value
  logic signed [VW-1:0] eff [LEN];        // line after an optional restart
  logic [LEN-1:0]       le_thr;
  logic [LEN-1:0]       ge_neg_thr;
  logic [DELAY_SPAN-1:0] tap_a_bits;
  logic [DELAY_SPAN-1:0] tap_b_bits;
  logic signed [CW-1:0] thr_x;
  logic signed [CW-1:0] neg_thr_x;
  logic                 term_a;
  logic                 term_b;
  logic                 up;
  logic signed [VW-1:0] cur;
  logic signed [VW-1:0] next_value;

  assign adv           = a_valid && hist_ready;
  assign item_in.ready = !a_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      a_restart <= item_in.restart;
      a_draw    <= item_in.rand_draw;
    end
  end

  assign thr_x     = CW'(threshold);
  assign neg_thr_x = -thr_x;

  // Per-entry compares sit at fixed places; the delays only pick a bit
  always_comb begin
    for (int k = 0; k < LEN; k++) begin
      if (a_restart) begin
        eff[k] = (k == 0) ? ONE : '0;
      end else begin
        eff[k] = hist_line[k];
      end
      le_thr[k]     = CW'(eff[k]) <= thr_x;
      ge_neg_thr[k] = CW'(eff[k]) >= neg_thr_x;
    end
  end

  // Delay wraps modulo HISTORY_DEPTH
  for (genvar d = 0; d < DELAY_SPAN; d++) begin : g_tap
    assign tap_a_bits[d] = le_thr[d % HISTORY_DEPTH];
    assign tap_b_bits[d] = ge_neg_thr[d % HISTORY_DEPTH];
  end

  always_comb begin
    term_a = tap_a_bits[delay_a];
    term_b = tap_b_bits[delay_b];
    if (term_a != term_b) begin
      up = term_a;
    end else begin
      up = !a_draw[DRAW_W-1];  // draw below one half
    end
    cur = eff[0];
    if (up) begin
      next_value = (cur == HR_POS) ? HR_POS : cur + ONE;
    end else begin
      next_value = (cur == HR_NEG) ? HR_NEG : cur - ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEN; k++) begin
        hist_line[k] <= (k == 0) ? ONE : '0;
      end
    end else if (adv) begin
      hist_line[0] <= next_value;
      for (int k = 1; k < LEN; k++) begin
        hist_line[k] <= eff[k-1];
      end
    end
  end

  assign ctl.adv     = adv;
  assign ctl.restart = a_restart;
  assign value       = next_value;
  assign bin         = BW'(next_value + HR_POS);

endmodule

/* design/dfrw_hist.sv */
// ----------------------------------------------------------------------------
// dfrw_hist: histogram update and result register
// Reads the bin count, increments it with saturation, writes it back and
// presents the result item. Valid bits stand in for clearing the counts.
// ----------------------------------------------------------------------------
module dfrw_hist #(
  parameter int HALF_RANGE = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  dfrw_pkg::step_ctl_t                     ctl,
  input  logic signed [$clog2(HALF_RANGE + 1):0]  value,
  input  logic [$clog2(2 * HALF_RANGE + 1)-1:0]   bin,
  output logic                                    hist_ready,
  dfrw_out_if.source                              item_out
);
  import dfrw_pkg::*;

  localparam int VW       = $clog2(HALF_RANGE + 1) + 1;
  localparam int NUM_BINS = 2 * HALF_RANGE + 1;
  localparam int BW       = $clog2(NUM_BINS);

  logic                 b_valid;
  logic                 b_restart;
  logic                 b_hit;
  logic signed [VW-1:0] b_value;
  logic [BW-1:0]        b_bin;
  logic [COUNT_W-1:0]   rdata;

  logic                 last_valid;
  logic [BW-1:0]        last_bin;
  logic [COUNT_W-1:0]   last_count;

  logic [NUM_BINS-1:0]  bin_vld;

  logic                 o_valid;
  logic [VALUE_W-1:0]   o_value;
  logic [COUNT_W-1:0]   o_count;

  logic                 adv_out;
  logic [COUNT_W-1:0]   base;
  logic [COUNT_W-1:0]   count_new;

  assign adv_out    = b_valid && (!o_valid || item_out.ready);
  assign hist_ready = !b_valid || adv_out;

  dfrw_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (adv_out),
    .waddr (b_bin),
    .wdata (count_new),
    .re    (ctl.adv),
    .raddr (bin),
    .rdata (rdata)
  );

  // The previous item's write may land on the same edge as this read
  always_comb begin
    if (b_restart) begin
      base = '0;
    end else if (last_valid && last_bin == b_bin) begin
      base = last_count;
    end else if (b_hit) begin
      base = rdata;
    end else begin
      base = '0;
    end
    count_new = (&base) ? base : base + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ctl.adv) begin
      b_valid <= 1'b1;
    end else if (adv_out) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      b_restart <= ctl.restart;
      b_value   <= value;
      b_bin     <= bin;
      b_hit     <= bin_vld[bin];
    end
  end

  // Restart clears every bin; it wins over an older item's write
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
    end else if (ctl.adv && ctl.restart) begin
      bin_vld <= '0;
    end else if (adv_out) begin
      bin_vld[b_bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (adv_out) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      last_bin   <= b_bin;
      last_count <= count_new;
      o_value    <= VALUE_W'(b_value);
      o_count    <= count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv_out) begin
      o_valid <= 1'b1;
    end else if (item_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  assign item_out.valid     = o_valid;
  assign item_out.new_value = o_value;
  assign item_out.bin_count = o_count;

endmodule

/* design/delayed_feedback_random_walk_unit.sv */
// ----------------------------------------------------------------------------
// delayed_feedback_random_walk_unit: bounded random walk with delayed feedback
// Steps a walk bounded to +-HALF_RANGE once per input item, steered by two
// delayed taps of its own history, and counts visits per walk value.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result item per input item, in
// order; a result passes the input register, the histogram read stage and
// the result register, and is taken at an edge where the output side is
// ready; either side may stall at any time. The rate is set by the walk
// step itself: the taps come from a shift line of the last min(HISTORY_DEPTH,
// 32) values, so a step sees the value of the step before it with no bubble.
// The per-value counts live in a RAM of 2*HALF_RANGE+1 words with one valid
// bit per word, so reset and restart clear them at once and no clearing pass
// is needed. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while no item is in flight, as the block does not
// enforce this; an index with no register is ignored.
// ----------------------------------------------------------------------------
module delayed_feedback_random_walk_unit #(
  parameter int HALF_RANGE    = 10,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dfrw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfrw_pkg::CFG_W-1:0]         cfg_data,
  dfrw_in_if.sink                            item_in,
  dfrw_out_if.source                         item_out
);
  import dfrw_pkg::*;

  localparam int VW = $clog2(HALF_RANGE + 1) + 1;
  localparam int BW = $clog2(2 * HALF_RANGE + 1);

  // Configuration registers
  logic signed [CFG_W-1:0] threshold;
  logic [CFG_W-1:0]        delay_a;
  logic [CFG_W-1:0]        delay_b;

  // Step stage to histogram stage
  step_ctl_t            ctl;
  logic signed [VW-1:0] value;
  logic [BW-1:0]        bin;
  logic                 hist_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      delay_a   <= DELAY_A_RST;
      delay_b   <= DELAY_B_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data;
        REG_DELAY_A:   delay_a   <= cfg_data;
        REG_DELAY_B:   delay_b   <= cfg_data;
        default: ;  // no register at this index
      endcase
    end
  end

  // Input register, history line and step decision
  dfrw_step #(
    .HALF_RANGE    (HALF_RANGE),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .threshold  (threshold),
    .delay_a    (delay_a),
    .delay_b    (delay_b),
    .hist_ready (hist_ready),
    .ctl        (ctl),
    .value      (value),
    .bin        (bin)
  );

  // Count read-modify-write and result register
  dfrw_hist #(
    .HALF_RANGE (HALF_RANGE)
  ) u_hist (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .value      (value),
    .bin        (bin),
    .hist_ready (hist_ready),
    .item_out   (item_out)
  );

endmodule
